// File: rtl/integer_to_ascii_radix_core_assert.svh
// Assertion macros shared by the conversion core and its divider.
`ifndef INTEGER_TO_ASCII_RADIX_CORE_ASSERT_SVH
`define INTEGER_TO_ASCII_RADIX_CORE_ASSERT_SVH

// Checked on every clock edge except while reset is applied.
`define ITOA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checked on every clock edge, reset included.
`define ITOA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// File: rtl/itoa_pkg.sv
`default_nettype none

package itoa_pkg;

    // Width of the integer being converted.
    localparam int VALUE_BITS = 32;

    // The divider retires this many quotient bits per cycle.
    localparam int STEP_BITS  = 8;
    localparam int DIV_CYCLES = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
    localparam int DIV_W      = DIV_CYCLES * STEP_BITS;
    localparam int DCNT_W     = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

    // Input stream data is the value padded to whole bytes.
    localparam int IN_TDATA_W = DIV_W;

    // Radix 2 gives the longest digit string.
    localparam int MAX_DIGITS = VALUE_BITS;
    localparam int IDX_W      = $clog2(MAX_DIGITS);
    localparam int CNT_W      = $clog2(MAX_DIGITS + 1);

    localparam int RADIX_W = 6;
    localparam int DIGIT_W = 5;
    localparam int CHAR_W  = 7;
    localparam int OUT_TDATA_W = 8;

    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd32;
    localparam logic [RADIX_W-1:0] RADIX_DEC   = 6'd10;

    localparam logic [CHAR_W-1:0] ASCII_ZERO   = 7'd48;
    localparam logic [CHAR_W-1:0] ASCII_LETTER = 7'd65;
    localparam logic [CHAR_W-1:0] ASCII_MINUS  = 7'd45;
    localparam logic [CHAR_W-1:0] DIGIT_TEN    = 7'd10;

    // Configuration address map: one register, word index in paddr[2].
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_RADIX = 1'b0;

    // Status of the shared divider as seen by the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // Map a digit value to its ASCII character.
    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] dz;
        dz = CHAR_W'(d);
        if (dz >= DIGIT_TEN)
        begin
            return ASCII_LETTER + dz - DIGIT_TEN;
        end
        return ASCII_ZERO + dz;
    endfunction

endpackage

`default_nettype wire

// File: rtl/itoa_div.sv
`default_nettype none

// Restoring divider by the radix, STEP_BITS quotient bits per cycle.
module itoa_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [itoa_pkg::DIV_W-1:0]    dividend,
    input  wire logic [itoa_pkg::RADIX_W-1:0]  divisor,
    output itoa_pkg::div_stat_t                stat,
    output logic      [itoa_pkg::DIV_W-1:0]    quotient,
    output logic      [itoa_pkg::DIGIT_W-1:0]  remainder
);
    import itoa_pkg::*;

    `include "integer_to_ascii_radix_core_assert.svh"

    logic [DIV_W-1:0]   dq_reg, dq_next;
    logic [DIGIT_W-1:0] rem_reg, rem_next;
    logic [RADIX_W-1:0] div_reg;
    logic [DCNT_W-1:0]  cnt_reg;
    logic               busy_reg;
    logic               done_reg;

    // Several shift-subtract steps on the narrow partial remainder.
    always_comb
    begin
        logic [DIGIT_W:0]   t;
        logic [DIGIT_W-1:0] r;
        logic [DIV_W-1:0]   d;
        r = rem_reg;
        d = dq_reg;
        for (int i = 0; i < STEP_BITS; i++)
        begin
            t = {r, d[DIV_W-1]};
            d = {d[DIV_W-2:0], 1'b0};
            if (t >= div_reg)
            begin
                t    = t - div_reg;
                d[0] = 1'b1;
            end
            r = t[DIGIT_W-1:0];
        end
        rem_next = r;
        dq_next  = d;
    end

    // Control: load on start, step while busy until the step count is reached, pulse done.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DCNT_W'(DIV_CYCLES - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dq_reg  <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            dq_reg  <= dq_next;
            rem_reg <= rem_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = dq_reg;
    assign remainder = rem_reg;

    `ITOA_ASSERT(a_start_idle, start |-> !busy_reg, "divider started while busy")
    `ITOA_ASSERT(a_done_after_busy, done_reg |-> $past(busy_reg), "done without a run")
    `ITOA_ASSERT(a_rem_below_div, done_reg |-> ({1'b0, rem_reg} < div_reg),
        "remainder not below divisor")

endmodule

`default_nettype wire

// File: rtl/integer_to_ascii_radix_core.sv
// Each digit costs one division by the radix in the shared divider.
// A new request is accepted only once the core is back in idle; a sign character and output stalls delay that.
// The longest result is a 32-digit binary string.
// Reset: rst_n is asynchronous, active low; radix returns to 10 and the core goes idle.
`default_nettype none

module integer_to_ascii_radix_core (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // Input stream: tdata = value[31:0] (signed in radix 10, unsigned in every other radix).
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [itoa_pkg::IN_TDATA_W-1:0]   s_tdata,
    // Output stream: tdata = char_code[6:0], zero pad[7]; tlast = last.
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic      [itoa_pkg::OUT_TDATA_W-1:0]  m_tdata,
    output logic                                   m_tlast,
    // Configuration port.
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [itoa_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [itoa_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [itoa_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                   pready
);
    import itoa_pkg::*;

    `include "integer_to_ascii_radix_core_assert.svh"

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]         state_reg;
    logic [RADIX_W-1:0] radix_reg;
    logic               neg_reg;
    logic [CNT_W-1:0]   ndig_reg;
    logic [CNT_W-1:0]   ptr_reg;
    logic [DIGIT_W-1:0] dig_mem [MAX_DIGITS];
    logic               m_tvalid_reg;
    logic [CHAR_W-1:0]  char_reg;
    logic               last_reg;

    logic               s_accept;
    logic               cfg_write;
    logic [RADIX_W-1:0] wr_radix;
    logic               in_neg;
    logic [VALUE_BITS-1:0] in_val;
    logic [VALUE_BITS-1:0] in_mag;
    logic               div_start;
    logic [DIV_W-1:0]   div_dividend;
    div_stat_t          div_stat;
    logic [DIV_W-1:0]   div_quot;
    logic [DIGIT_W-1:0] div_rem;
    logic               q_zero;
    logic               out_load;
    logic [CNT_W-1:0]   ptr_dec;

    // Configuration register: out-of-range radix writes are dropped.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_RADIX);
    assign wr_radix  = pwdata[RADIX_W-1:0];
    assign prdata    = (paddr[2] == REG_RADIX) ? APB_DATA_W'(radix_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= RADIX_RESET;
        end
        else if (cfg_write && (wr_radix >= RADIX_MIN) && (wr_radix <= RADIX_MAX))
        begin
            radix_reg <= wr_radix;
        end
    end

    // Input side: only decimal treats the value as signed.
    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign in_val   = s_tdata[VALUE_BITS-1:0];
    assign in_neg   = (radix_reg == RADIX_DEC) && in_val[VALUE_BITS-1];
    assign in_mag   = in_neg ? (~in_val + 1'b1) : in_val;

    // Each division starts from the input or from the previous quotient.
    assign q_zero       = (div_quot == '0);
    assign div_start    = s_accept || (div_stat.done && !q_zero);
    assign div_dividend = s_accept ? DIV_W'(in_mag) : div_quot;

    itoa_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (radix_reg),
        .stat      (div_stat),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    // Digits arrive least significant first and are read back in reverse.
    always_ff @(posedge clk)
    begin
        if (div_stat.done)
        begin
            dig_mem[ndig_reg[IDX_W-1:0]] <= div_rem;
        end
    end

    assign ptr_dec  = ptr_reg - 1'b1;
    assign out_load = (state_reg == ST_EMIT) && (!m_tvalid_reg || m_tready);

    // Sequencer: divide until the quotient is zero, then emit the string.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            neg_reg   <= 1'b0;
            ndig_reg  <= '0;
            ptr_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (s_accept)
                    begin
                        neg_reg   <= in_neg;
                        ndig_reg  <= '0;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (div_stat.done)
                    begin
                        ndig_reg <= ndig_reg + 1'b1;
                        if (q_zero)
                        begin
                            ptr_reg   <= ndig_reg + 1'b1;
                            state_reg <= ST_EMIT;
                        end
                    end
                end
                ST_EMIT:
                begin
                    if (out_load)
                    begin
                        if (neg_reg)
                        begin
                            neg_reg <= 1'b0;
                        end
                        else
                        begin
                            ptr_reg <= ptr_dec;
                            if (ptr_dec == '0)
                            begin
                                state_reg <= ST_IDLE;
                            end
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Output register decouples the result stream from the sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            if (neg_reg)
            begin
                char_reg <= ASCII_MINUS;
                last_reg <= 1'b0;
            end
            else
            begin
                char_reg <= digit_char(dig_mem[ptr_dec[IDX_W-1:0]]);
                last_reg <= (ptr_dec == '0);
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_TDATA_W'(char_reg);
    assign m_tlast  = last_reg;

    `ITOA_ASSERT(a_div_after_accept, s_accept |=> div_stat.busy, "divider not started")
    `ITOA_ASSERT(a_done_in_div, div_stat.done |-> (state_reg == ST_DIV),
        "digit produced outside the divide phase")
    `ITOA_ASSERT(a_emit_has_digits, (state_reg == ST_EMIT) |-> (ptr_reg != '0),
        "emit phase with no digit left")
    `ITOA_ASSERT(a_digit_bound, ndig_reg <= CNT_W'(MAX_DIGITS),
        "digit count beyond storage")

endmodule

`default_nettype wire
